// File: sv/prot_pkg.sv
// ----------------------------------------------------------------------------
// prot_pkg
// Shared constants, transaction types and helpers for the provider refcount
// overuse tracker.
// ----------------------------------------------------------------------------
package prot_pkg;

  localparam int NUM_BINDINGS  = 64;
  localparam int NUM_PROVIDERS = 16;
  localparam int MAX_REFS      = 256;

  // fixed field widths of the transactions
  localparam int FUNC_W      = 2;
  localparam int BIND_W      = 6;
  localparam int PROV_W      = 4;
  localparam int CAP_W       = 9;
  localparam int TOTAL_OUT_W = 13;
  localparam int COUNT_OUT_W = 7;
  localparam int STATUS_W    = 2;

  localparam int COUNT_OUT_MAX = 127;
  localparam int TOTAL_OUT_MAX = 8191;

  // derived storage widths
  localparam int BIDX_W = (NUM_BINDINGS > 1) ? $clog2(NUM_BINDINGS) : 1;
  localparam int PIDX_W = (NUM_PROVIDERS > 1) ? $clog2(NUM_PROVIDERS) : 1;
  localparam int DEPTH  = NUM_BINDINGS * NUM_PROVIDERS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int REF_W  = $clog2(MAX_REFS + 1);
  localparam int CNT_W  = $clog2(NUM_BINDINGS + 1);
  localparam int SUM_W  = $clog2(DEPTH + 1);

  localparam logic [FUNC_W-1:0] FUNC_MOVE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CAP  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_ADD  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SATURATED = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [BIND_W-1:0] binding_index;
    logic [PROV_W-1:0] old_provider;
    logic [PROV_W-1:0] new_provider;
    logic [CAP_W-1:0]  capacity_value;
  } cmd_t;

  typedef struct packed {
    logic [TOTAL_OUT_W-1:0] overuse_total;
    logic [COUNT_OUT_W-1:0] old_provider_count;
    logic [COUNT_OUT_W-1:0] new_provider_count;
    logic [STATUS_W-1:0]    status;
  } rsp_t;

  typedef enum logic [1:0] {
    STEP_HOLD = 2'd0,
    STEP_INC  = 2'd1,
    STEP_DEC  = 2'd2
  } step_t;

  // control handed to the shared excess unit
  typedef struct packed {
    step_t            step;
    logic [CAP_W-1:0] cap_after;
  } xs_op_t;

  // reduce a binding index modulo NUM_BINDINGS by restoring subtraction
  function automatic logic [BIDX_W-1:0] wrap_bind(input logic [BIND_W-1:0] v);
    logic [BIND_W:0] r;
    r = {1'b0, v};
    for (int k = BIND_W - 1; k >= 0; k--) begin
      if ((NUM_BINDINGS << k) < (2 ** (BIND_W + 1)) && int'(r) >= (NUM_BINDINGS << k)) begin
        r = r - (BIND_W + 1)'(NUM_BINDINGS << k);
      end
    end
    return BIDX_W'(r);
  endfunction

  function automatic logic [PIDX_W-1:0] wrap_prov(input logic [PROV_W-1:0] v);
    logic [PROV_W:0] r;
    r = {1'b0, v};
    for (int k = PROV_W - 1; k >= 0; k--) begin
      if ((NUM_PROVIDERS << k) < (2 ** (PROV_W + 1)) && int'(r) >= (NUM_PROVIDERS << k)) begin
        r = r - (PROV_W + 1)'(NUM_PROVIDERS << k);
      end
    end
    return PIDX_W'(r);
  endfunction

  function automatic logic [ADDR_W-1:0] slot(input logic [BIDX_W-1:0] b,
                                             input logic [PIDX_W-1:0] p);
    return ADDR_W'(int'(b) * NUM_PROVIDERS + int'(p));
  endfunction

  function automatic logic [COUNT_OUT_W-1:0] clamp_count(input logic [CNT_W-1:0] c);
    if (int'(c) > COUNT_OUT_MAX) begin
      return COUNT_OUT_W'(COUNT_OUT_MAX);
    end
    return COUNT_OUT_W'(c);
  endfunction

  function automatic logic [TOTAL_OUT_W-1:0] clamp_total(input logic [SUM_W-1:0] s);
    if (int'(s) > TOTAL_OUT_MAX) begin
      return TOTAL_OUT_W'(TOTAL_OUT_MAX);
    end
    return TOTAL_OUT_W'(s);
  endfunction

endpackage

// File: sv/provider_refcount_overuse_tracker_top.sv
// ----------------------------------------------------------------------------
// provider_refcount_overuse_tracker_top
// Per (binding, provider) reference counts, distinct-binding counts per
// provider and the running overuse total, updated one command at a time.
// ----------------------------------------------------------------------------
// After reset the block sweeps the pair count store, one entry a cycle, over
// all NUM_BINDINGS * NUM_PROVIDERS entries and holds cmd_stall high meanwhile.
// It then takes one command at a time. A move reads the old and new pair
// counts, checks them and writes the old then the new one, but skips the
// writes when refused for underflow or saturation. An add reads, checks and
// writes the new pair count only, skipping the write when saturated. A
// capacity write touches no pair count; a move between equal providers and
// the unused code go straight to the report. The pair count store does one
// registered read and one write a cycle, and the one shared excess unit
// handles one provider per cycle. Each response sits in an output register,
// so a stalled response does not block the acceptance of the next command;
// that command is held in its last cycle until the register is free.
// ----------------------------------------------------------------------------
module provider_refcount_overuse_tracker_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_stall,
  input  prot_pkg::cmd_t   cmd,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output prot_pkg::rsp_t   rsp
);

  typedef enum logic [9:0] {
    S_CLEAR   = 10'b00_0000_0001,
    S_IDLE    = 10'b00_0000_0010,
    S_RD_OLD  = 10'b00_0000_0100,
    S_RD_NEW  = 10'b00_0000_1000,
    S_CHECK   = 10'b00_0001_0000,
    S_UPD_OLD = 10'b00_0010_0000,
    S_UPD_NEW = 10'b00_0100_0000,
    S_CAP     = 10'b00_1000_0000,
    S_RPT_OLD = 10'b01_0000_0000,
    S_DONE    = 10'b10_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  logic [prot_pkg::FUNC_W-1:0]   func;
  logic [prot_pkg::BIDX_W-1:0]   bidx;
  logic [prot_pkg::PIDX_W-1:0]   oldp;
  logic [prot_pkg::PIDX_W-1:0]   newp;
  logic [prot_pkg::CAP_W-1:0]    capv;
  logic [prot_pkg::REF_W-1:0]    old_ref;
  logic [prot_pkg::REF_W-1:0]    new_ref;
  logic [prot_pkg::STATUS_W-1:0] status;
  logic [prot_pkg::CNT_W-1:0]    old_cnt_rpt;
  logic [prot_pkg::ADDR_W-1:0]   clr_addr;
  logic [prot_pkg::SUM_W-1:0]    sum;
  logic [prot_pkg::CNT_W-1:0]    pbc [prot_pkg::NUM_PROVIDERS];
  logic [prot_pkg::CAP_W-1:0]    cap [prot_pkg::NUM_PROVIDERS];

  logic                          cmd_take;
  logic                          rsp_free;
  logic [prot_pkg::PIDX_W-1:0]   prov_sel;
  logic [prot_pkg::ADDR_W-1:0]   old_slot;
  logic [prot_pkg::ADDR_W-1:0]   new_slot;

  logic                          mem_we;
  logic [prot_pkg::ADDR_W-1:0]   mem_wr_addr;
  logic [prot_pkg::REF_W-1:0]    mem_wr_data;
  logic [prot_pkg::ADDR_W-1:0]   mem_rd_addr;
  logic [prot_pkg::REF_W-1:0]    mem_rd_data;

  prot_pkg::xs_op_t              xs_op;
  logic [prot_pkg::CNT_W-1:0]    xs_cnt_after;
  logic [prot_pkg::SUM_W-1:0]    xs_sum_out;

  logic                          ref_full;

  assign cmd_stall = (state != S_IDLE);
  assign cmd_take  = cmd_valid && !cmd_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign old_slot  = prot_pkg::slot(bidx, oldp);
  assign new_slot  = prot_pkg::slot(bidx, newp);
  assign prov_sel  = (state == S_UPD_NEW || state == S_DONE) ? newp : oldp;
  assign ref_full  = (mem_rd_data >= prot_pkg::REF_W'(prot_pkg::MAX_REFS));

  // pair count store port control
  always_comb begin
    mem_we      = 1'b0;
    mem_wr_addr = clr_addr;
    mem_wr_data = '0;
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_UPD_OLD: begin
        mem_we      = 1'b1;
        mem_wr_addr = old_slot;
        mem_wr_data = old_ref - prot_pkg::REF_W'(1);
      end
      S_UPD_NEW: begin
        mem_we      = 1'b1;
        mem_wr_addr = new_slot;
        mem_wr_data = new_ref + prot_pkg::REF_W'(1);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
    mem_rd_addr = (state == S_RD_OLD) ? old_slot : new_slot;
  end

  prot_pair_mem u_pair_mem (
    .clk     (clk),
    .we      (mem_we),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  always_comb begin
    xs_op.step      = prot_pkg::STEP_HOLD;
    xs_op.cap_after = cap[prov_sel];
    case (state)
      S_UPD_OLD: begin
        if (old_ref == prot_pkg::REF_W'(1)) begin
          xs_op.step = prot_pkg::STEP_DEC;
        end
      end
      S_UPD_NEW: begin
        if (new_ref == '0) begin
          xs_op.step = prot_pkg::STEP_INC;
        end
      end
      S_CAP: begin
        xs_op.cap_after = capv;
      end
      default: begin
        xs_op.step = prot_pkg::STEP_HOLD;
      end
    endcase
  end

  prot_excess_unit u_excess (
    .cnt_before (pbc[prov_sel]),
    .cap_before (cap[prov_sel]),
    .op         (xs_op),
    .sum_in     (sum),
    .cnt_after  (xs_cnt_after),
    .sum_out    (xs_sum_out)
  );

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_addr == prot_pkg::ADDR_W'(prot_pkg::DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_take) begin
          case (cmd.func)
            prot_pkg::FUNC_MOVE: begin
              if (prot_pkg::wrap_prov(cmd.old_provider) !=
                  prot_pkg::wrap_prov(cmd.new_provider)) begin
                state_next = S_RD_OLD;
              end else begin
                state_next = S_RPT_OLD;
              end
            end
            prot_pkg::FUNC_ADD: state_next = S_RD_NEW;
            prot_pkg::FUNC_CAP: state_next = S_CAP;
            default:            state_next = S_RPT_OLD;
          endcase
        end
      end
      S_RD_OLD:  state_next = S_RD_NEW;
      S_RD_NEW:  state_next = S_CHECK;
      S_CHECK: begin
        if (func == prot_pkg::FUNC_MOVE) begin
          if (old_ref == '0 || ref_full) begin
            state_next = S_RPT_OLD;
          end else begin
            state_next = S_UPD_OLD;
          end
        end else if (ref_full) begin
          state_next = S_RPT_OLD;
        end else begin
          state_next = S_UPD_NEW;
        end
      end
      S_UPD_OLD: state_next = S_UPD_NEW;
      S_UPD_NEW: state_next = S_RPT_OLD;
      S_CAP:     state_next = S_RPT_OLD;
      S_RPT_OLD: state_next = S_DONE;
      S_DONE: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      sum       <= '0;
      rsp_valid <= 1'b0;
      for (int i = 0; i < prot_pkg::NUM_PROVIDERS; i++) begin
        pbc[i] <= '0;
        cap[i] <= '0;
      end
    end else begin
      state <= state_next;

      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + prot_pkg::ADDR_W'(1);
      end

      if (cmd_take) begin
        func   <= cmd.func;
        bidx   <= prot_pkg::wrap_bind(cmd.binding_index);
        oldp   <= prot_pkg::wrap_prov(cmd.old_provider);
        newp   <= prot_pkg::wrap_prov(cmd.new_provider);
        capv   <= cmd.capacity_value;
        status <= prot_pkg::ST_OK;
      end

      if (state == S_RD_NEW) begin
        old_ref <= mem_rd_data;
      end

      if (state == S_CHECK) begin
        new_ref <= mem_rd_data;
        // underflow takes precedence over saturation
        if (func == prot_pkg::FUNC_MOVE && old_ref == '0) begin
          status <= prot_pkg::ST_UNDERFLOW;
        end else if (ref_full) begin
          status <= prot_pkg::ST_SATURATED;
        end
      end

      if (state == S_UPD_OLD || state == S_UPD_NEW || state == S_CAP) begin
        pbc[prov_sel] <= xs_cnt_after;
        sum           <= xs_sum_out;
      end

      if (state == S_CAP) begin
        cap[prov_sel] <= capv;
      end

      if (state == S_RPT_OLD) begin
        old_cnt_rpt <= pbc[prov_sel];
      end

      // output register: load on completion, drop once taken
      if (state == S_DONE && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && rsp_free) begin
      rsp.overuse_total      <= prot_pkg::clamp_total(sum);
      rsp.old_provider_count <= prot_pkg::clamp_count(old_cnt_rpt);
      rsp.new_provider_count <= prot_pkg::clamp_count(pbc[prov_sel]);
      rsp.status             <= status;
    end
  end

endmodule

// File: sv/prot_pair_mem.sv
// ----------------------------------------------------------------------------
// prot_pair_mem
// Single-write, single-read pair reference count store with registered read.
// ----------------------------------------------------------------------------
module prot_pair_mem (
  input  logic                       clk,
  input  logic                       we,
  input  logic [prot_pkg::ADDR_W-1:0] wr_addr,
  input  logic [prot_pkg::REF_W-1:0]  wr_data,
  input  logic [prot_pkg::ADDR_W-1:0] rd_addr,
  output logic [prot_pkg::REF_W-1:0]  rd_data
);

  logic [prot_pkg::REF_W-1:0] mem [prot_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: sv/prot_excess_unit.sv
// ----------------------------------------------------------------------------
// prot_excess_unit
// Shared unit: steps one provider's binding count and folds the change in
// that provider's overuse into the running total.
// ----------------------------------------------------------------------------
module prot_excess_unit (
  input  logic [prot_pkg::CNT_W-1:0] cnt_before,
  input  logic [prot_pkg::CAP_W-1:0] cap_before,
  input  prot_pkg::xs_op_t           op,
  input  logic [prot_pkg::SUM_W-1:0] sum_in,
  output logic [prot_pkg::CNT_W-1:0] cnt_after,
  output logic [prot_pkg::SUM_W-1:0] sum_out
);

  localparam int XW = (prot_pkg::CNT_W > prot_pkg::CAP_W) ?
                      prot_pkg::CNT_W : prot_pkg::CAP_W;

  logic [prot_pkg::CNT_W-1:0] xs_before;
  logic [prot_pkg::CNT_W-1:0] xs_after;

  function automatic logic [prot_pkg::CNT_W-1:0] excess(
    input logic [prot_pkg::CNT_W-1:0] c,
    input logic [prot_pkg::CAP_W-1:0] cap
  );
    logic [XW-1:0] cw;
    logic [XW-1:0] kw;
    cw = XW'(c);
    kw = XW'(cap);
    if (cw > kw) begin
      return prot_pkg::CNT_W'(cw - kw);
    end
    return '0;
  endfunction

  always_comb begin
    case (op.step)
      prot_pkg::STEP_INC: cnt_after = cnt_before + prot_pkg::CNT_W'(1);
      prot_pkg::STEP_DEC: cnt_after = cnt_before - prot_pkg::CNT_W'(1);
      default:            cnt_after = cnt_before;
    endcase
  end

  assign xs_before = excess(cnt_before, cap_before);
  assign xs_after  = excess(cnt_after, op.cap_after);
  assign sum_out   = prot_pkg::SUM_W'({1'b0, sum_in}
                                      - (prot_pkg::SUM_W + 1)'(xs_before)
                                      + (prot_pkg::SUM_W + 1)'(xs_after));

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks the provider refcount overuse tracker against a shadow copy of its
// pair counts, per-provider binding counts, capacities and overuse total.
// A short directed run covers the corner cases. Random traffic follows,
// mostly legal moves and adds, with a saturation burst, a full provider and
// random gaps on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import prot_pkg::*;

  // func code with no operation behind it
  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

  class refcount_shadow;
    int unsigned pair_refs[DEPTH];
    int unsigned bound[NUM_PROVIDERS];
    int unsigned cap[NUM_PROVIDERS];
    int unsigned overuse;
    rsp_t        pending[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned status_seen[3];

    function new();
      overuse = 0;
      errors  = 0;
      checked = 0;
      foreach (pair_refs[i]) pair_refs[i] = 0;
      foreach (bound[i]) bound[i] = 0;
      foreach (cap[i]) cap[i] = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int unsigned excess(int unsigned p);
      return (bound[p] > cap[p]) ? bound[p] - cap[p] : 0;
    endfunction

    function int unsigned refs_of(int unsigned b, int unsigned p);
      return pair_refs[b * NUM_PROVIDERS + p];
    endfunction

    // first provider from start on that holds a reference of binding b
    function int holder(int unsigned b, int unsigned start);
      int unsigned p;
      for (int k = 0; k < NUM_PROVIDERS; k++) begin
        p = (start + k) % NUM_PROVIDERS;
        if (refs_of(b, p) != 0) return p;
      end
      return -1;
    endfunction

    function void step_pair(int unsigned b, int unsigned p, bit up);
      int unsigned s;
      int unsigned was;
      s   = b * NUM_PROVIDERS + p;
      was = excess(p);
      if (up) begin
        if (pair_refs[s] == 0) bound[p]++;
        pair_refs[s]++;
      end else begin
        pair_refs[s]--;
        if (pair_refs[s] == 0) bound[p]--;
      end
      overuse = overuse - was + excess(p);
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("ERROR: %s", msg);
    endfunction

    function void note_cmd(cmd_t c);
      int unsigned b;
      int unsigned op;
      int unsigned np;
      int unsigned was;
      rsp_t        r;
      b  = int'(c.binding_index) % NUM_BINDINGS;
      op = int'(c.old_provider) % NUM_PROVIDERS;
      np = int'(c.new_provider) % NUM_PROVIDERS;
      r.status = ST_OK;
      case (c.func)
        FUNC_MOVE: begin
          if (op != np) begin
            if (refs_of(b, op) == 0) begin
              r.status = ST_UNDERFLOW;
            end else if (refs_of(b, np) >= MAX_REFS) begin
              r.status = ST_SATURATED;
            end else begin
              step_pair(b, op, 1'b0);
              step_pair(b, np, 1'b1);
            end
          end
        end
        FUNC_CAP: begin
          was     = excess(op);
          cap[op] = c.capacity_value;
          overuse = overuse - was + excess(op);
        end
        FUNC_ADD: begin
          if (refs_of(b, np) >= MAX_REFS) r.status = ST_SATURATED;
          else step_pair(b, np, 1'b1);
        end
        default: ;
      endcase
      r.overuse_total      = TOTAL_OUT_W'((overuse > TOTAL_OUT_MAX) ? TOTAL_OUT_MAX : overuse);
      r.old_provider_count = COUNT_OUT_W'((bound[op] > COUNT_OUT_MAX) ? COUNT_OUT_MAX : bound[op]);
      r.new_provider_count = COUNT_OUT_W'((bound[np] > COUNT_OUT_MAX) ? COUNT_OUT_MAX : bound[np]);
      status_seen[r.status]++;
      pending = {pending, r};
    endfunction

    function void check_rsp(rsp_t got);
      rsp_t want;
      if (pending.size() == 0) begin
        flag($sformatf("response with nothing outstanding: total %0d old %0d new %0d st %0d",
                       got.overuse_total, got.old_provider_count,
                       got.new_provider_count, got.status));
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.overuse_total !== want.overuse_total ||
          got.old_provider_count !== want.old_provider_count ||
          got.new_provider_count !== want.new_provider_count ||
          got.status !== want.status) begin
        flag($sformatf({"response %0d: expected total %0d old %0d new %0d st %0d, ",
                        "got total %0d old %0d new %0d st %0d"}, checked,
                       want.overuse_total, want.old_provider_count,
                       want.new_provider_count, want.status,
                       got.overuse_total, got.old_provider_count,
                       got.new_provider_count, got.status));
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cmd_valid;
  logic cmd_stall;
  cmd_t cmd;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  refcount_shadow shadow;
  bit             gaps_on;
  int unsigned    cmds_sent;

  provider_refcount_overuse_tracker_top uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(negedge clk) begin
    rsp_stall <= gaps_on && ($urandom_range(0, 99) < 11);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_valid && !cmd_stall) shadow.note_cmd(cmd);
      if (rsp_valid && !rsp_stall) shadow.check_rsp(rsp);
    end
  end

  // called and returns at a falling edge; valid is left high on return and drops only for a random gap or a drain
  task automatic send_cmd(input cmd_t c);
    while (gaps_on && $urandom_range(0, 99) < 11) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd       <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
    cmds_sent++;
    @(negedge clk);
  endtask

  task automatic issue(input logic [FUNC_W-1:0] f, input int b, input int op,
                       input int np, input int cv);
    cmd_t c;
    c.func           = f;
    c.binding_index  = BIND_W'(b);
    c.old_provider   = PROV_W'(op);
    c.new_provider   = PROV_W'(np);
    c.capacity_value = CAP_W'(cv);
    send_cmd(c);
  endtask

  // hold off until every outstanding response is back
  task automatic drain();
    cmd_valid <= 1'b0;
    do @(negedge clk); while (shadow.pending.size() != 0);
  endtask

  // push one pair to its reference limit, then try to go past it both ways
  task automatic saturate_pair();
    int b;
    int p;
    int q;
    b = $urandom_range(0, NUM_BINDINGS - 1);
    p = $urandom_range(0, NUM_PROVIDERS - 1);
    q = (p + 1 + $urandom_range(0, NUM_PROVIDERS - 2)) % NUM_PROVIDERS;
    while (shadow.refs_of(b, p) < MAX_REFS) issue(FUNC_ADD, b, q, p, 0);
    issue(FUNC_ADD, b, q, p, 0);
    issue(FUNC_ADD, b, p, q, 0);
    issue(FUNC_MOVE, b, q, p, 0);
    issue(FUNC_MOVE, b, p, q, 0);
  endtask

  // every binding onto one provider, then squeeze its capacity
  task automatic fill_provider();
    int p;
    p = $urandom_range(0, NUM_PROVIDERS - 1);
    for (int b = 0; b < NUM_BINDINGS; b++) begin
      issue(FUNC_ADD, b, $urandom_range(0, 15), p, $urandom_range(0, 511));
    end
    issue(FUNC_CAP, 0, p, 0, 0);
    issue(FUNC_CAP, 0, p, 0, 40);
  endtask

  task automatic random_item();
    int pick;
    int b;
    int p;
    int q;
    int h;
    int cv;
    pick = $urandom_range(0, 99);
    b    = $urandom_range(0, NUM_BINDINGS - 1);
    p    = $urandom_range(0, NUM_PROVIDERS - 1);
    q    = $urandom_range(0, NUM_PROVIDERS - 1);
    cv   = $urandom_range(0, 511);
    if (pick < 40) begin
      h = shadow.holder(b, p);
      if (h < 0) issue(FUNC_ADD, b, p, q, cv);
      else issue(FUNC_MOVE, b, h, q, cv);
    end else if (pick < 65) begin
      issue(FUNC_ADD, b, p, q, cv);
    end else if (pick < 80) begin
      // mostly capacities near the live counts so overuse moves both ways
      if (pick < 78) cv = $urandom_range(0, 12);
      issue(FUNC_CAP, b, p, q, cv);
    end else if (pick < 90) begin
      issue(FUNC_MOVE, b, p, q, cv);
    end else if (pick < 95) begin
      issue(FUNC_MOVE, b, p, p, cv);
    end else begin
      issue(FUNC_SPARE, b, p, q, cv);
    end
  endtask

  initial begin
    shadow    = new();
    rst       = 1'b1;
    cmd_valid = 1'b0;
    cmd       = '0;
    rsp_stall = 1'b0;
    gaps_on   = 1'b1;
    cmds_sent = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    issue(FUNC_SPARE, 63, 15, 15, 511);
    issue(FUNC_MOVE, 0, 0, 1, 0);
    issue(FUNC_ADD, 0, 15, 0, 0);
    issue(FUNC_ADD, 63, 0, 15, 256);
    issue(FUNC_ADD, 63, 0, 15, 0);
    issue(FUNC_MOVE, 63, 15, 15, 0);
    issue(FUNC_MOVE, 63, 15, 0, 0);
    issue(FUNC_MOVE, 63, 15, 0, 0);
    issue(FUNC_MOVE, 63, 15, 0, 0);
    issue(FUNC_CAP, 63, 0, 15, 1);
    issue(FUNC_CAP, 0, 15, 0, 511);
    issue(FUNC_CAP, 0, 15, 0, 256);
    issue(FUNC_CAP, 0, 15, 0, 0);
    issue(FUNC_ADD, 5, 0, 0, 0);
    issue(FUNC_CAP, 0, 0, 0, 3);
    issue(FUNC_SPARE, 0, 0, 15, 0);
    issue(FUNC_ADD, 42, 10, 5, 0);
    issue(FUNC_MOVE, 42, 5, 10, 0);
    drain();

    for (int i = 0; i < 900; i++) begin
      gaps_on = !(i >= 300 && i < 500);
      if (i == 150) saturate_pair();
      if (i == 450) drain();
      if (i == 600) fill_provider();
      random_item();
    end

    cmd_valid <= 1'b0;
    gaps_on = 1'b1;
    while (shadow.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    if (shadow.pending.size() != 0) begin
      shadow.flag($sformatf("%0d responses never arrived", shadow.pending.size()));
    end
    $display("Ran %0d commands, %0d responses checked, %0d mismatches", cmds_sent,
             shadow.checked, shadow.errors);
    $display("Statuses: ok %0d, underflow %0d, saturated %0d", shadow.status_seen[0],
             shadow.status_seen[1], shadow.status_seen[2]);
    if (shadow.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
